@@ sv/spd_pkg.sv @@
// shared types and constants of the strict priority dispatcher
package spd_pkg;

  // item opcodes
  localparam logic OP_SUBMIT   = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  // fixed field widths of the item interfaces
  localparam int unsigned PRIO_FW  = 3;
  localparam int unsigned TAG_FW   = 16;
  localparam int unsigned OUTS_FW  = 8;
  localparam int unsigned CFG_FW   = 4;
  localparam int unsigned IN_DW    = 24;
  localparam int unsigned OUT_DW   = 32;

  // priorities in use after reset
  localparam logic [CFG_FW-1:0] CFG_RESET = 4'd8;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADPRIO = 2'd2,
    ST_IDLE    = 2'd3
  } status_t;

endpackage

@@ sv/spd_pick.sv @@
// lowest-numbered non-empty queue picker
module spd_pick import spd_pkg::*; #(
  parameter int unsigned NUM_QUEUES = 8,
  parameter int unsigned PW         = 3
) (
  input  logic [NUM_QUEUES-1:0] nonempty,
  output logic                  found,
  output logic [PW-1:0]         idx
);

  // scan from the least urgent queue down so the most urgent wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
      if (nonempty[q]) begin
        found = 1'b1;
        idx   = PW'(q);
      end
    end
  end

endmodule

@@ sv/spd_tag_ram.sv @@
// tag store: one write port, one registered read port
module spd_tag_ram #(
  parameter int unsigned AW = 7,
  parameter int unsigned DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];
  logic [DW-1:0] rdata_r;

  // write and read, read data held while no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/strict_priority_serial_dispatcher_core.sv @@
// Strict priority serial dispatcher: one tag FIFO per priority, at most one
// task running. The block takes one item per clock cycle while the result side does not stall;
// an item is captured in an input register, processed in a single pass
// against the queue pointers and fill counts, and its result is registered
// in the output register.
// A submit while nothing is outstanding dispatches its own tag directly; a
// completion with tasks left pops the most urgent non-empty queue through
// the registered read port of the tag memory, whose read register supplies the popped tag.
// Stalls on the result side hold the pipeline; no clearing pass is needed
// after reset.
module strict_priority_serial_dispatcher_core import spd_pkg::*; #(
  parameter int unsigned NUM_QUEUES  = 8,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration: priorities in use
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_FW-1:0] cfg_data,
  // input items
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // priority_req[2:0], task_tag[18:3], zero pad
  input  logic [0:0]        in_tuser,   // opcode[0]
  // result items
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // dispatched[0], dispatched_tag[16:1],
                                        // dispatched_priority[19:17], status[21:20],
                                        // outstanding[29:22], zero pad
);

  localparam int unsigned PW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CW = $clog2(NUM_QUEUES * QUEUE_DEPTH + 2);
  localparam int unsigned AW = PW + QW;

  function automatic logic [QW-1:0] wrap_next(input logic [QW-1:0] p);
    return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // configuration register
  logic [CFG_FW-1:0] prio_lim_r;
  logic [4:0]        limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_lim_r <= CFG_RESET;
    end else if (cfg_valid) begin
      prio_lim_r <= cfg_data;
    end
  end

  // effective priority count, clamped to one .. NUM_QUEUES
  always_comb begin
    limit = {1'b0, prio_lim_r};
    if (limit == 5'd0) begin
      limit = 5'd1;
    end else if (limit > 5'(NUM_QUEUES)) begin
      limit = 5'(NUM_QUEUES);
    end
  end

  // input register
  logic                 in_valid_r;
  logic                 op_r;
  logic [PRIO_FW-1:0]   prio_r;
  logic [TAG_WIDTH-1:0] tag_r;
  logic                 advance;
  logic                 out_valid_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser[0];
      prio_r <= in_tdata[PRIO_FW-1:0];
      tag_r  <= TAG_WIDTH'(in_tdata[PRIO_FW +: TAG_FW]);
    end
  end

  // queue state
  logic [QW-1:0] head_r [NUM_QUEUES];
  logic [QW-1:0] tail_r [NUM_QUEUES];
  logic [FW-1:0] fill_r [NUM_QUEUES];
  logic [CW-1:0] cnt_r;
  logic [QW-1:0] head_nxt [NUM_QUEUES];
  logic [QW-1:0] tail_nxt [NUM_QUEUES];
  logic [FW-1:0] fill_nxt [NUM_QUEUES];
  logic [CW-1:0] cnt_nxt;

  logic [NUM_QUEUES-1:0] nonempty;
  logic                  pick_found;
  logic [PW-1:0]         pick_idx;

  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      nonempty[q] = (fill_r[q] != '0);
    end
  end

  spd_pick #(
    .NUM_QUEUES (NUM_QUEUES),
    .PW         (PW)
  ) u_pick (
    .nonempty (nonempty),
    .found    (pick_found),
    .idx      (pick_idx)
  );

  // single pass over the item in the input register
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic          disp;
  logic          from_mem;
  logic [PW-1:0] dprio;
  status_t       status;
  logic [PW-1:0] pi;

  assign pi = PW'(prio_r);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {pi, tail_r[pi]};
    mem_raddr = {pick_idx, head_r[pick_idx]};
    disp      = 1'b0;
    from_mem  = 1'b0;
    dprio     = '0;
    status    = ST_OK;
    if (op_r == OP_SUBMIT) begin
      if ({2'b00, prio_r} >= limit) begin
        status = ST_BADPRIO;
      end else if (fill_r[pi] == FW'(QUEUE_DEPTH)) begin
        status = ST_FULL;
      end else begin
        tail_nxt[pi] = wrap_next(tail_r[pi]);
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == '0) begin
          // all queues empty: the new task starts straight away
          head_nxt[pi] = wrap_next(tail_r[pi]);
          disp         = 1'b1;
          dprio        = pi;
        end else begin
          mem_we       = advance;
          fill_nxt[pi] = fill_r[pi] + 1'b1;
        end
      end
    end else begin
      if (cnt_r == '0) begin
        status = ST_IDLE;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r != CW'(1) && pick_found) begin
          // pop the most urgent waiting task
          mem_re             = advance;
          head_nxt[pick_idx] = wrap_next(head_r[pick_idx]);
          fill_nxt[pick_idx] = fill_r[pick_idx] - 1'b1;
          disp               = 1'b1;
          from_mem           = 1'b1;
          dprio              = pick_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_r[q] <= '0;
        tail_r[q] <= '0;
        fill_r[q] <= '0;
      end
      cnt_r <= '0;
    end else if (advance) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // tag store
  logic [TAG_WIDTH-1:0] mem_rdata;

  spd_tag_ram #(
    .AW (AW),
    .DW (TAG_WIDTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (tag_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register
  logic                 out_disp_r;
  logic                 out_mem_r;
  logic [TAG_WIDTH-1:0] out_tag_r;
  logic [PW-1:0]        out_prio_r;
  status_t              out_status_r;
  logic [CW-1:0]        out_cnt_r;
  logic [TAG_FW-1:0]    out_dtag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_disp_r   <= disp;
      out_mem_r    <= from_mem;
      out_tag_r    <= tag_r;
      out_prio_r   <= dprio;
      out_status_r <= status;
      out_cnt_r    <= cnt_nxt;
    end
  end

  // popped tags come from the memory read register
  always_comb begin
    if (!out_disp_r) begin
      out_dtag = '0;
    end else if (out_mem_r) begin
      out_dtag = TAG_FW'(mem_rdata);
    end else begin
      out_dtag = TAG_FW'(out_tag_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, OUTS_FW'(out_cnt_r), out_status_r,
                       PRIO_FW'(out_prio_r), out_dtag, out_disp_r};

  // checks
  a_one_mem_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("tag store written and read for one item");

  a_idle_queues_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (nonempty == '0))
    else $error("queue holds tasks while nothing is outstanding");

  a_no_disp_no_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_disp_r) |-> (out_dtag == '0 && out_prio_r == '0))
    else $error("tag or priority reported without a dispatch");

  a_pop_finds_task: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && op_r == OP_COMPLETE && cnt_r > CW'(1)) |-> pick_found)
    else $error("tasks outstanding but every queue empty");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed item left no result");

endmodule

@@ test/strict_priority_serial_dispatcher_core_tb.sv @@
// self-checking testbench of the strict priority serial dispatcher core
`timescale 1ns / 1ps

module strict_priority_serial_dispatcher_core_tb;
  import spd_pkg::*;

  localparam int NPRIO  = 8;
  localparam int QDEPTH = 16;
  localparam int N_DIR  = 23;

  // receiver stall patterns
  localparam int RX_FREE   = 0;
  localparam int RX_PATCHY = 1;
  localparam int RX_SLOW   = 2;

  // one result item, first member in the top bits
  typedef struct packed {
    logic             disp;
    logic [15:0]      tag;
    logic [2:0]       prio;
    status_t          status;
    logic [7:0]       outs;
  } disp_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // one row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    row_kind_t        kind;
    logic             op;
    logic [2:0]       prio;
    logic [15:0]      tag;
    logic [3:0]       cfg;
    logic [4:0]       reps;
    logic             typed;
    disp_res_t        res;
  } stim_row_t;

  localparam disp_res_t NO_RES = '{1'b0, 16'h0000, 3'd0, ST_OK, 8'd0};

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_FW-1:0] cfg_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic [0:0]        in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;

  // predictor state
  logic [15:0]       tag_mem [NPRIO][QDEPTH];
  int                q_head [NPRIO] = '{default: 0};
  int                q_tail [NPRIO] = '{default: 0};
  int                q_fill [NPRIO] = '{default: 0};
  int                busy_cnt = 0;
  logic [3:0]        prio_lim = CFG_RESET;

  disp_res_t         pending_dispatch_q [$];
  int                mism = 0;
  int                burst_left = 0;
  bit                hold_req = 0;

  stim_row_t         dir_tab [N_DIR];

  strict_priority_serial_dispatcher_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // priority count as the block applies it: 0 acts as 1, above the queue count clamps
  function automatic int eff_prio_count();
    if (prio_lim == 4'd0) return 1;
    if (prio_lim > NPRIO) return NPRIO;
    return int'(prio_lim);
  endfunction

  // updates the queue state for one item and returns its dispatch result
  function automatic disp_res_t predict_dispatch(logic op, logic [2:0] p, logic [15:0] t);
    disp_res_t r;
    bit        do_pop;
    r = NO_RES;
    do_pop = 1'b0;
    if (op == OP_SUBMIT) begin
      if (int'(p) >= eff_prio_count()) begin
        r.status = ST_BADPRIO;
      end else if (q_fill[p] >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        tag_mem[p][q_tail[p]] = t;
        q_tail[p] = (q_tail[p] + 1) % QDEPTH;
        q_fill[p]++;
        if (busy_cnt == 0) do_pop = 1'b1;
        busy_cnt++;
      end
    end else begin
      if (busy_cnt == 0) begin
        r.status = ST_IDLE;
      end else begin
        busy_cnt--;
        if (busy_cnt > 0) do_pop = 1'b1;
      end
    end
    // most urgent non-empty queue, scanning all of them
    if (do_pop) begin
      for (int q = 0; q < NPRIO; q++) begin
        if (!r.disp && q_fill[q] != 0) begin
          r.disp = 1'b1;
          r.tag = tag_mem[q][q_head[q]];
          r.prio = 3'(q);
          q_head[q] = (q_head[q] + 1) % QDEPTH;
          q_fill[q]--;
        end
      end
    end
    r.outs = 8'(busy_cnt);
    return r;
  endfunction

  function automatic void report(string what, disp_res_t want, disp_res_t got);
    mism++;
    if (mism <= 10)
      $display("%0t %s: expected disp=%0d tag=%h prio=%0d st=%0d outs=%0d, got disp=%0d tag=%h prio=%0d st=%0d outs=%0d",
               $realtime, what, want.disp, want.tag, want.prio, want.status, want.outs,
               got.disp, got.tag, got.prio, got.status, got.outs);
  endfunction

  // send one item in bursts with random gaps; called and left at a falling edge
  task automatic send_item(input logic op, input logic [2:0] p, input logic [15:0] t,
                           input logic typed, input disp_res_t typed_res);
    disp_res_t pr;
    int        gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(40, 1);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, t, p};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    pr = predict_dispatch(op, p, t);
    pending_dispatch_q.push_back(typed ? typed_res : pr);
    @(negedge clk);
  endtask

  // hold the sender until every expected result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_dispatch_q.size() != 0);
  endtask

  task automatic write_prio_limit(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    prio_lim = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int mode_left;
    mode = RX_FREE;
    mode_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (150) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(RX_SLOW, RX_FREE);
          mode_left = $urandom_range(60, 5);
        end
        mode_left--;
        case (mode)
          RX_FREE:   out_tready <= 1'b1;
          RX_PATCHY: out_tready <= 1'($urandom_range(1));
          default:   out_tready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin : check_results
    disp_res_t got;
    disp_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = disp_res_t'({out_tdata[0], out_tdata[16:1], out_tdata[19:17],
                         out_tdata[21:20], out_tdata[29:22]});
      if (pending_dispatch_q.size() == 0) begin
        report("unexpected result", NO_RES, got);
      end else begin
        want = pending_dispatch_q.pop_front();
        if (got !== want) report("result mismatch", want, got);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    stim_row_t  row;
    logic       op;
    logic       run_op;
    logic [2:0] p;
    logic [2:0] run_prio;
    logic [15:0] t;
    logic [3:0] phase_cfg [7];
    int         run_left;
    int         bias;
    int         lim;
    int         pick;
    int         cnt;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    run_left   = 0;
    run_op     = OP_SUBMIT;
    run_prio   = 3'd0;
    phase_cfg  = '{4'd3, 4'd8, 4'd6, 4'd1, 4'd15, 4'd0, 4'd8};

    // config rows carry the register value, item rows may repeat with rising tags
    dir_tab = '{
      '{ROW_ITEM, OP_COMPLETE, 3'd0, 16'h0000, 4'd0, 5'd1, 1'b1,
        '{1'b0, 16'h0000, 3'd0, ST_IDLE, 8'd0}},
      '{ROW_ITEM, OP_SUBMIT, 3'd0, 16'hFFFF, 4'd0, 5'd1, 1'b1,
        '{1'b1, 16'hFFFF, 3'd0, ST_OK, 8'd1}},
      '{ROW_ITEM, OP_SUBMIT, 3'd7, 16'h0000, 4'd0, 5'd1, 1'b1,
        '{1'b0, 16'h0000, 3'd0, ST_OK, 8'd2}},
      '{ROW_ITEM, OP_SUBMIT, 3'd3, 16'h1234, 4'd0, 5'd1, 1'b0, NO_RES},
      '{ROW_ITEM, OP_SUBMIT, 3'd7, 16'hAAAA, 4'd0, 5'd1, 1'b0, NO_RES},
      '{ROW_ITEM, OP_COMPLETE, 3'd0, 16'h0000, 4'd0, 5'd3, 1'b0, NO_RES},
      '{ROW_ITEM, OP_COMPLETE, 3'd0, 16'h0000, 4'd0, 5'd1, 1'b1,
        '{1'b0, 16'h0000, 3'd0, ST_OK, 8'd0}},
      '{ROW_ITEM, OP_COMPLETE, 3'd5, 16'hFFFF, 4'd0, 5'd1, 1'b1,
        '{1'b0, 16'h0000, 3'd0, ST_IDLE, 8'd0}},
      // one running plus sixteen queued fills priority five
      '{ROW_ITEM, OP_SUBMIT, 3'd5, 16'h5550, 4'd0, 5'd17, 1'b0, NO_RES},
      '{ROW_ITEM, OP_SUBMIT, 3'd5, 16'hFFFF, 4'd0, 5'd1, 1'b1,
        '{1'b0, 16'h0000, 3'd0, ST_FULL, 8'd17}},
      '{ROW_CFG, OP_SUBMIT, 3'd0, 16'h0000, 4'd1, 5'd1, 1'b0, NO_RES},
      '{ROW_ITEM, OP_SUBMIT, 3'd1, 16'h0001, 4'd0, 5'd1, 1'b1,
        '{1'b0, 16'h0000, 3'd0, ST_BADPRIO, 8'd17}},
      '{ROW_ITEM, OP_SUBMIT, 3'd0, 16'h8000, 4'd0, 5'd1, 1'b0, NO_RES},
      // zero behaves as one
      '{ROW_CFG, OP_SUBMIT, 3'd0, 16'h0000, 4'd0, 5'd1, 1'b0, NO_RES},
      '{ROW_ITEM, OP_SUBMIT, 3'd4, 16'h0F0F, 4'd0, 5'd1, 1'b1,
        '{1'b0, 16'h0000, 3'd0, ST_BADPRIO, 8'd18}},
      '{ROW_ITEM, OP_SUBMIT, 3'd0, 16'h7FFE, 4'd0, 5'd1, 1'b0, NO_RES},
      // completions still drain priority five although it is now out of range
      '{ROW_ITEM, OP_COMPLETE, 3'd0, 16'h0000, 4'd0, 5'd3, 1'b0, NO_RES},
      // above the queue count clamps to eight
      '{ROW_CFG, OP_SUBMIT, 3'd0, 16'h0000, 4'd15, 5'd1, 1'b0, NO_RES},
      '{ROW_ITEM, OP_SUBMIT, 3'd7, 16'hF0F0, 4'd0, 5'd1, 1'b0, NO_RES},
      '{ROW_ITEM, OP_SUBMIT, 3'd6, 16'h00FF, 4'd0, 5'd1, 1'b0, NO_RES},
      '{ROW_ITEM, OP_COMPLETE, 3'd0, 16'h0000, 4'd0, 5'd2, 1'b0, NO_RES},
      '{ROW_CFG, OP_SUBMIT, 3'd0, 16'h0000, 4'd8, 5'd1, 1'b0, NO_RES},
      '{ROW_ITEM, OP_SUBMIT, 3'd2, 16'h3C3C, 4'd0, 5'd1, 1'b0, NO_RES}
    };

    // hold reset, then release it
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        write_prio_limit(row.cfg);
      end else begin
        for (int k = 0; k < int'(row.reps); k++)
          send_item(row.op, row.prio, row.tag + 16'(k), row.typed, row.res);
      end
    end

    // random phases, one register setting each
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      write_prio_limit(phase_cfg[ph]);
      bias = $urandom_range(65, 40);
      for (int k = 0; k < 65; k++) begin
        if (ph == 1 && k == 10) hold_req = 1'b1;
        if (ph == 3 && k == 30) wait_drained();
        lim = eff_prio_count();
        // occasional runs: fill one queue to full, or drain to idle and beyond
        if (run_left == 0) begin
          pick = $urandom_range(99);
          if (pick < 3) begin
            run_op = OP_SUBMIT;
            run_prio = 3'($urandom_range(lim - 1));
            run_left = 18;
          end else if (pick < 6) begin
            run_op = OP_COMPLETE;
            run_left = busy_cnt + 2;
          end
        end
        p = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(lim - 1));
        t = 16'($urandom);
        if (run_left > 0) begin
          op = run_op;
          if (run_op == OP_SUBMIT) p = run_prio;
          run_left--;
        end else begin
          op = ($urandom_range(99) < bias) ? OP_SUBMIT : OP_COMPLETE;
        end
        send_item(op, p, t, 1'b0, NO_RES);
      end
    end

    // let the last results come back
    in_tvalid <= 1'b0;
    cnt = 0;
    while (pending_dispatch_q.size() != 0 && cnt < 50000) begin
      @(negedge clk);
      cnt++;
    end
    repeat (8) @(negedge clk);
    if (pending_dispatch_q.size() != 0) begin
      $display("%0d expected results never arrived", pending_dispatch_q.size());
      mism += pending_dispatch_q.size();
    end
    if (mism == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
sv/spd_pkg.sv
sv/spd_pick.sv
sv/spd_tag_ram.sv
sv/strict_priority_serial_dispatcher_core.sv
test/strict_priority_serial_dispatcher_core_tb.sv
